[hw/rtl/mdrc_pkg.sv]
// shared types and constants for the duplicate row/column eliminator
// used by mdrc_seq and the core top level
package mdrc_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ELEM_W   = 64;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 6;
  localparam int CNT_W    = 7;
  localparam int ADDR_W   = ROW_W + COL_W;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  // unused code, no effect
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef struct packed {
    logic [1:0]        op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [ELEM_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [ELEM_W-1:0] read_value;
    logic [CNT_W-1:0]  kept_rows;
    logic [CNT_W-1:0]  kept_cols;
    logic              in_range;
  } res_t;

endpackage

[hw/rtl/mdrc_ram.sv]
// generic ram: one write port, two registered read ports
// no dependencies
module mdrc_ram #(
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hw/rtl/mdrc_seq.sv]
// sequencer: element writes, dedup walk over the shared compare unit,
// compacted reads; depends on mdrc_pkg and mdrc_ram
module mdrc_seq
  import mdrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             start,
  input  item_t            item,
  output logic             idle,
  output logic             done,
  output res_t             res
);

  typedef enum logic [2:0] {
    S_IDLE, S_A, S_B, S_K, S_C, S_SCAN, S_RD, S_FIN
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   rows_cfg_r, cols_cfg_r;
  logic [MAX_ROWS-1:0] row_mask_r, row_mask_nxt;
  logic [MAX_COLS-1:0] col_mask_r, col_mask_nxt;
  logic [CNT_W-1:0]   krow_r, krow_nxt, kcol_r, kcol_nxt;
  logic               ph_r, ph_nxt;
  logic               keep_r, keep_nxt;
  logic [CNT_W-1:0]   a_r, a_nxt, b_r, b_nxt, k_r, k_nxt;
  logic [ROW_W-1:0]   q_row_r, q_row_nxt, pr_r, pr_nxt;
  logic [COL_W-1:0]   q_col_r, q_col_nxt, pc_r, pc_nxt;
  logic [CNT_W-1:0]   rc_r, rc_nxt, cc_r, cc_nxt;

  logic [CNT_W-1:0]   nr, nc, n_outer, n_inner;
  logic               mem_we;
  logic [ADDR_W-1:0]  ra_a, ra_b;
  logic [ELEM_W-1:0]  rd_a, rd_b;
  logic               same;
  logic               wr_ok, rd_ok;
  logic               cur_mask_b;

  // saturated dimensions
  assign nr = (rows_cfg_r > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_cfg_r;
  assign nc = (cols_cfg_r > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : cols_cfg_r;
  assign n_outer = ph_r ? nc : nr;
  assign n_inner = ph_r ? nr : nc;

  assign wr_ok = ({1'b0, item.row} < nr) && ({1'b0, item.col} < nc);
  assign rd_ok = ({1'b0, item.row} < krow_r) && ({1'b0, item.col} < kcol_r);
  assign mem_we = start && (item.op == OP_WRITE) && wr_ok;

  // ram addresses: a read addresses the found position; row phase walks rows a and b, column phase walks columns
  always_comb begin
    if (state_r == S_RD) begin
      ra_a = {pr_r, pc_r};
      ra_b = {pr_r, pc_r};
    end else if (ph_r) begin
      ra_a = {k_r[ROW_W-1:0], a_r[COL_W-1:0]};
      ra_b = {k_r[ROW_W-1:0], b_r[COL_W-1:0]};
    end else begin
      ra_a = {a_r[ROW_W-1:0], k_r[COL_W-1:0]};
      ra_b = {b_r[ROW_W-1:0], k_r[COL_W-1:0]};
    end
  end

  mdrc_ram #(.WIDTH(ELEM_W), .ADDR_W(ADDR_W)) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   ({item.row, item.col}),
    .wdata   (item.value),
    .raddr_a (ra_a),
    .raddr_b (ra_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // shared compare unit
  assign same = (rd_a == rd_b);
  assign cur_mask_b = ph_r ? col_mask_r[b_r[COL_W-1:0]] : row_mask_r[b_r[ROW_W-1:0]];

  assign idle = (state_r == S_IDLE);

  // next state and datapath
  always_comb begin
    state_nxt    = state_r;
    row_mask_nxt = row_mask_r;
    col_mask_nxt = col_mask_r;
    krow_nxt     = krow_r;
    kcol_nxt     = kcol_r;
    ph_nxt       = ph_r;
    keep_nxt     = keep_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    k_nxt        = k_r;
    q_row_nxt    = q_row_r;
    q_col_nxt    = q_col_r;
    pr_nxt       = pr_r;
    pc_nxt       = pc_r;
    rc_nxt       = rc_r;
    cc_nxt       = cc_r;
    done         = 1'b0;
    res          = '0;
    res.kept_rows = krow_r;
    res.kept_cols = kcol_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          q_row_nxt = item.row;
          q_col_nxt = item.col;
          case (item.op)
            OP_WRITE: begin
              done         = 1'b1;
              res.in_range = wr_ok;
            end
            OP_COMPUTE: begin
              ph_nxt    = 1'b0;
              a_nxt     = '0;
              krow_nxt  = '0;
              state_nxt = S_A;
            end
            OP_READ: begin
              if (rd_ok) begin
                a_nxt     = '0;
                rc_nxt    = '0;
                cc_nxt    = '0;
                state_nxt = S_SCAN;
              end else begin
                done = 1'b1;
              end
            end
            default: done = 1'b1;
          endcase
        end
      end
      // start of one outer index, or the phase switch or the finish after the last one
      S_A: begin
        if (a_r == CNT_W'(MAX_ROWS) && !ph_r) begin
          ph_nxt   = 1'b1;
          a_nxt    = '0;
          kcol_nxt = '0;
        end else if (a_r == CNT_W'(MAX_COLS) && ph_r) begin
          state_nxt = S_FIN;
        end else begin
          keep_nxt  = (a_r < n_outer);
          b_nxt     = '0;
          state_nxt = S_B;
        end
      end
      // pick the next earlier kept index or settle this one
      S_B: begin
        if (!keep_r || b_r == a_r) begin
          if (ph_r) begin
            col_mask_nxt[a_r[COL_W-1:0]] = keep_r;
            kcol_nxt = kcol_r + CNT_W'(keep_r);
          end else begin
            row_mask_nxt[a_r[ROW_W-1:0]] = keep_r;
            krow_nxt = krow_r + CNT_W'(keep_r);
          end
          a_nxt     = a_r + 1'b1;
          state_nxt = S_A;
        end else if (!cur_mask_b) begin
          b_nxt = b_r + 1'b1;
        end else begin
          k_nxt     = '0;
          state_nxt = S_K;
        end
      end
      // issue one element pair, or finish with a full match
      S_K: begin
        if (k_r == n_inner) begin
          keep_nxt  = 1'b0;
          state_nxt = S_B;
        end else if (ph_r && !row_mask_r[k_r[ROW_W-1:0]]) begin
          k_nxt = k_r + 1'b1;
        end else begin
          state_nxt = S_C;
        end
      end
      // compare the pair
      S_C: begin
        if (!same) begin
          b_nxt     = b_r + 1'b1;
          state_nxt = S_B;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_K;
        end
      end
      // find the original row and column of a compacted position
      S_SCAN: begin
        if (row_mask_r[a_r[ROW_W-1:0]]) begin
          if (rc_r == {1'b0, q_row_r}) pr_nxt = a_r[ROW_W-1:0];
          rc_nxt = rc_r + 1'b1;
        end
        if (col_mask_r[a_r[COL_W-1:0]]) begin
          if (cc_r == {1'b0, q_col_r}) pc_nxt = a_r[COL_W-1:0];
          cc_nxt = cc_r + 1'b1;
        end
        a_nxt = a_r + 1'b1;
        if (a_r == CNT_W'(MAX_ROWS - 1)) state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        done           = 1'b1;
        res.in_range   = 1'b1;
        res.read_value = ph_r ? '0 : rd_a;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rows_cfg_r <= CNT_W'(1);
      cols_cfg_r <= CNT_W'(1);
      row_mask_r <= '1;
      col_mask_r <= '1;
      krow_r     <= CNT_W'(1);
      kcol_r     <= CNT_W'(1);
      ph_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      row_mask_r <= row_mask_nxt;
      col_mask_r <= col_mask_nxt;
      krow_r     <= krow_nxt;
      kcol_r     <= kcol_nxt;
      ph_r       <= (state_r == S_IDLE && start && item.op == OP_READ) ? 1'b0 : ph_nxt;
      if (cfg_we && cfg_addr == CFG_ROWS) rows_cfg_r <= cfg_wdata;
      if (cfg_we && cfg_addr == CFG_COLS) cols_cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    keep_r  <= keep_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    k_r     <= k_nxt;
    q_row_r <= q_row_nxt;
    q_col_r <= q_col_nxt;
    pr_r    <= pr_nxt;
    pc_r    <= pc_nxt;
    rc_r    <= rc_nxt;
    cc_r    <= cc_nxt;
  end

  // checks
  a_cmp_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_C) |-> ($past(state_r) == S_K))
    else $error("compare without an issued pair");
  a_row_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && ph_r) |-> (krow_r == CNT_W'($countones(row_mask_r))))
    else $error("kept row count disagrees with row mask");
  a_col_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && ph_r) |-> (kcol_r == CNT_W'($countones(col_mask_r))))
    else $error("kept column count disagrees with column mask");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !idle) |=> idle)
    else $error("sequencer busy after finishing");

endmodule

[hw/rtl/matrix_duplicate_row_col_removal_core.sv]
// top level of the duplicate row/column eliminator: stream ports and result register
// depends on mdrc_pkg and mdrc_seq
//
//  channel  dir  tdata fields (low bit up)                    tuser
//  in_      in   row[5:0] col[11:6] value[75:12] (pad to 80)   op[1:0]
//  out_     out  read_value[63:0] kept_rows[70:64]
//                kept_cols[77:71] (pad to 80)                  in_range
//  cfg_     in   cfg_addr 0 rows_in_use, 1 cols_in_use
//
// writes and rejected requests finish in the cycle they are taken; a read
// of a kept position scans both masks over all 64 positions, then reads memory
// a compute walks every row pair, then every column pair, through one compare
// unit, issuing each element pair in S_K and comparing it in S_C
// reset is synchronous on rst_n; the element memory is not cleared
// a new request is taken only while idle and the result register is free or drained
module matrix_duplicate_row_col_removal_core
  import mdrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [79:0]      in_tdata,   // row, col, value
  input  logic [1:0]       in_tuser,   // op
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [79:0]      out_tdata,  // read_value, kept_rows, kept_cols
  output logic             out_tuser,  // in_range
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [CNT_W-1:0] cfg_wdata
);

  logic  seq_idle, seq_done, start;
  item_t item;
  res_t  res, res_r;
  logic  out_vld_r;

  // unpack request
  assign item.op    = in_tuser;
  assign item.row   = in_tdata[ROW_W-1:0];
  assign item.col   = in_tdata[ROW_W+COL_W-1:ROW_W];
  assign item.value = in_tdata[ADDR_W+ELEM_W-1:ADDR_W];

  assign in_tready = seq_idle && (!out_vld_r || out_tready);
  assign start     = in_tvalid && in_tready;

  mdrc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .item      (item),
    .idle      (seq_idle),
    .done      (seq_done),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (seq_done) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, res_r.kept_cols, res_r.kept_rows, res_r.read_value};
  assign out_tuser  = res_r.in_range;

endmodule

[verif/mdrc_checker.sv]
// result checker for the duplicate row/column eliminator: watches the request, result
// and register ports, predicts each result and compares it; depends on mdrc_pkg
module mdrc_checker
  import mdrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [79:0]      in_tdata,
  input  logic [1:0]       in_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [79:0]      out_tdata,
  input  logic             out_tuser,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [CNT_W-1:0] cfg_wdata,
  output int               errors,
  output int               pending,
  output int               checked
);

  // predictor state
  logic [ELEM_W-1:0] elem_mem [MAX_ROWS*MAX_COLS];
  bit   row_keep [MAX_ROWS];
  bit   col_keep [MAX_COLS];
  int   kept_rows_cnt;
  int   kept_cols_cnt;
  int   rows_reg;
  int   cols_reg;
  res_t expected_q [$];

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  function automatic int sat_dim(int v, int m);
    return (v > m) ? m : v;
  endfunction

  function automatic logic [ELEM_W-1:0] elem_at(int r, int c);
    return elem_mem[r*MAX_COLS + c];
  endfunction

  // drop repeated rows, then repeated columns over the surviving rows
  function automatic void dedup_matrix();
    int  nr;
    int  nc;
    bit  keep;
    bit  same;
    nr = sat_dim(rows_reg, MAX_ROWS);
    nc = sat_dim(cols_reg, MAX_COLS);
    kept_rows_cnt = 0;
    for (int a = 0; a < MAX_ROWS; a++) begin
      keep = (a < nr);
      for (int b = 0; keep && b < a; b++) begin
        if (!row_keep[b]) continue;
        same = 1'b1;
        for (int k = 0; k < nc; k++)
          if (elem_at(a, k) != elem_at(b, k)) begin
            same = 1'b0;
            break;
          end
        if (same) keep = 1'b0;
      end
      row_keep[a] = keep;
      if (keep) kept_rows_cnt++;
    end
    kept_cols_cnt = 0;
    for (int a = 0; a < MAX_COLS; a++) begin
      keep = (a < nc);
      for (int b = 0; keep && b < a; b++) begin
        if (!col_keep[b]) continue;
        same = 1'b1;
        for (int k = 0; k < nr; k++) begin
          if (!row_keep[k]) continue;
          if (elem_at(k, a) != elem_at(k, b)) begin
            same = 1'b0;
            break;
          end
        end
        if (same) keep = 1'b0;
      end
      col_keep[a] = keep;
      if (keep) kept_cols_cnt++;
    end
  endfunction

  // position of the n-th kept row or column, -1 if none
  function automatic int nth_kept(bit is_row, int n);
    int left;
    left = n;
    for (int i = 0; i < 64; i++) begin
      if (is_row ? row_keep[i] : col_keep[i]) begin
        if (left == 0) return i;
        left--;
      end
    end
    return -1;
  endfunction

  function automatic res_t predict_result(logic [1:0] op, int r, int c,
                                          logic [ELEM_W-1:0] v);
    res_t res;
    int   pr;
    int   pc;
    res = '0;
    case (op)
      OP_WRITE: begin
        if (r < sat_dim(rows_reg, MAX_ROWS) && c < sat_dim(cols_reg, MAX_COLS)) begin
          elem_mem[r*MAX_COLS + c] = v;
          res.in_range = 1'b1;
        end
      end
      OP_COMPUTE: begin
        dedup_matrix();
        res.in_range = 1'b1;
      end
      OP_READ: begin
        if (r < kept_rows_cnt && c < kept_cols_cnt) begin
          pr = nth_kept(1'b1, r);
          pc = nth_kept(1'b0, c);
          if (pr >= 0 && pc >= 0) begin
            res.read_value = elem_at(pr, pc);
            res.in_range   = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.kept_rows = kept_rows_cnt[CNT_W-1:0];
    res.kept_cols = kept_cols_cnt[CNT_W-1:0];
    return res;
  endfunction

  // sample at the falling edge; the values hold until the next rising edge
  always @(negedge clk) begin
    res_t exp_res;
    if (!rst_n) begin
      for (int i = 0; i < 64; i++) begin
        row_keep[i] = 1'b1;
        col_keep[i] = 1'b1;
      end
      rows_reg      = 1;
      cols_reg      = 1;
      kept_rows_cnt = 1;
      kept_cols_cnt = 1;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_ROWS) rows_reg = int'(cfg_wdata);
        else                      cols_reg = int'(cfg_wdata);
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(predict_result(in_tuser, int'(in_tdata[5:0]),
                                            int'(in_tdata[11:6]), in_tdata[75:12]));
      if (out_tvalid && out_tready) begin
        checked++;
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          exp_res = expected_q.pop_front();
          if (out_tdata[63:0] !== exp_res.read_value) begin
            $error("read_value expected %h got %h", exp_res.read_value, out_tdata[63:0]);
            errors++;
          end
          if (out_tdata[70:64] !== exp_res.kept_rows) begin
            $error("kept_rows expected %0d got %0d", exp_res.kept_rows, out_tdata[70:64]);
            errors++;
          end
          if (out_tdata[77:71] !== exp_res.kept_cols) begin
            $error("kept_cols expected %0d got %0d", exp_res.kept_cols, out_tdata[77:71]);
            errors++;
          end
          if (out_tuser !== exp_res.in_range) begin
            $error("in_range expected %0d got %0d", exp_res.in_range, out_tuser);
            errors++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

[verif/tb_matrix_duplicate_row_col_removal_core.sv]
// testbench top for the duplicate row/column eliminator: clock, reset, stimulus,
// receiver stalls and verdict; depends on mdrc_pkg, mdrc_checker and the core
module tb_matrix_duplicate_row_col_removal_core;
  import mdrc_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEM_GOAL   = 750;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [79:0]      in_tdata;   // row, col, value
  logic [1:0]       in_tuser;   // op
  logic             out_tvalid;
  logic             out_tready;
  logic [79:0]      out_tdata;  // read_value, kept_rows, kept_cols
  logic             out_tuser;  // in_range
  logic             cfg_we;
  logic             cfg_addr;
  logic [CNT_W-1:0] cfg_wdata;

  int  errors;
  int  pending;
  int  checked;
  int  cycles;
  int  n_items;
  int  n_writes;
  int  n_computes;
  int  n_reads;
  int  n_unused;
  bit  hold_req;
  bit  written [MAX_ROWS][MAX_COLS];
  int  eff_rows;
  int  eff_cols;

  matrix_duplicate_row_col_removal_core i_dut (.*);

  mdrc_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_addr, .cfg_wdata,
    .errors, .pending, .checked
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, a quiet window, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_tready <= (cycles > 20000 && cycles < 26000) || ($urandom_range(0, 99) >= 12);
        @(posedge clk);
      end
    end
  end

  // one request; returns at the rising edge where it was taken
  task automatic send(logic [1:0] op, int r, int c, logic [ELEM_W-1:0] v);
    bit took;
    while (!(n_items > 300 && n_items < 420) && $urandom_range(0, 99) < 12) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, v, c[5:0], r[5:0]};
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    n_items++;
    case (op)
      OP_WRITE:   n_writes++;
      OP_COMPUTE: n_computes++;
      OP_READ:    n_reads++;
      default:    n_unused++;
    endcase
    if (op == OP_WRITE && r < eff_rows && c < eff_cols) written[r][c] = 1'b1;
  endtask

  // let every outstanding result drain before a register write
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic addr, int val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val[CNT_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // few distinct patterns so duplicates show up often
  function automatic logic [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2:       return 64'h8000_0000_0000_0000;
      3:       return {$urandom, $urandom};
      default: return 64'($urandom_range(1, 3));
    endcase
  endfunction

  // every element inside the current size must hold data before a compute
  task automatic fill_and_compute();
    for (int r = 0; r < eff_rows; r++)
      for (int c = 0; c < eff_cols; c++)
        if (!written[r][c]) send(OP_WRITE, r, c, pick_value());
    send(OP_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 63), {$urandom, $urandom});
  endtask

  task automatic run_phase(int rows_cfg, int cols_cfg, int n);
    int sel;
    int r;
    int c;
    settle();
    write_cfg(CFG_ROWS, rows_cfg);
    write_cfg(CFG_COLS, cols_cfg);
    eff_rows = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
    eff_cols = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45 && eff_rows > 0 && eff_cols > 0) begin
        send(OP_WRITE, $urandom_range(0, eff_rows - 1), $urandom_range(0, eff_cols - 1),
             pick_value());
      end else if (sel < 55) begin
        send(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63), {$urandom, $urandom});
      end else if (sel < 85) begin
        r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, eff_rows);
        c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, eff_cols);
        send(OP_READ, r, c, {$urandom, $urandom});
      end else if (sel < 90) begin
        send(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63), {$urandom, $urandom});
      end else begin
        fill_and_compute();
      end
    end
    fill_and_compute();
    for (int k = 0; k < 4; k++)
      send(OP_READ, $urandom_range(0, eff_rows), $urandom_range(0, eff_cols), '0);
  endtask

  // stimulus
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_WRITE;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_ROWS;
    cfg_wdata = '0;
    hold_req  = 1'b0;
    n_items   = 0;
    n_writes  = 0;
    n_computes = 0;
    n_reads   = 0;
    n_unused  = 0;
    eff_rows  = 1;
    eff_cols  = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size 1x1: extremes, every op, out-of-range cases
    send(OP_WRITE, 0, 0, '1);
    send(OP_READ, 0, 0, '0);
    send(OP_READ, 1, 0, '0);
    send(OP_READ, 0, 63, '0);
    send(OP_NONE, 63, 63, '1);
    send(OP_COMPUTE, 0, 0, '0);
    send(OP_READ, 0, 0, '0);
    send(OP_WRITE, 0, 5, 64'h1234);
    send(OP_WRITE, 63, 63, '0);
    send(OP_READ, 0, 0, '0);

    // zero rows, oversize rows, oversize columns, then a long receiver hold-off
    run_phase(0, 3, 6);
    run_phase(127, 1, 8);
    run_phase(1, 127, 8);
    hold_req = 1'b1;
    run_phase(2, 2, 40);
    run_phase(64, 1, 10);

    while (n_items < ITEM_GOAL)
      run_phase($urandom_range(0, 3) == 0 ? $urandom_range(1, 16) : $urandom_range(1, 6),
                $urandom_range(0, 3) == 0 ? $urandom_range(1, 16) : $urandom_range(1, 6),
                60);

    settle();
    repeat (100) @(posedge clk);
    $display("covered %0d requests: %0d writes, %0d computes, %0d reads, %0d unused op",
             n_items, n_writes, n_computes, n_reads, n_unused);
    $display("sizes from empty to saturated 64; %0d results compared", checked);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mdrc_pkg.sv
hw/rtl/mdrc_ram.sv
hw/rtl/mdrc_seq.sv
hw/rtl/matrix_duplicate_row_col_removal_core.sv
verif/mdrc_checker.sv
verif/tb_matrix_duplicate_row_col_removal_core.sv
